FILE: hw/rtl/ffa_pkg.sv
// shared types and constants of the first-fit region allocator
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int OFS_W      = 31;
    localparam int OWN_W      = 8;
    localparam int ARITH_W    = OFS_W + 3;

    localparam logic [4:0]       MIN_ALIGN_LOG2 = 5'd12;
    localparam logic [OFS_W-1:0] TOP_LIMIT      = 31'h7FFF_FFFF;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic CFG_HEAP_START = 1'b0;
    localparam logic CFG_HEAP_SIZE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_NOT_OWNER  = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]       operation;
        logic [OFS_W-1:0] request_size;
        logic [4:0]       align_log2;
        logic [OFS_W-1:0] request_offset;
        logic [OWN_W-1:0] owner_id;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [OFS_W-1:0] block_offset;
    } t_out_item;

    typedef struct packed {
        logic [OFS_W-1:0] ent_start;
        logic [OFS_W-1:0] ent_size;
        logic [OWN_W-1:0] ent_owner;
    } t_entry;

endpackage
`default_nettype wire

FILE: hw/rtl/first_fit_aligned_region_allocator.sv
// top level of the first-fit aligned region allocator
// each table entry walked passes the read, decide and emit states; a split emits up to three entries
// one item at a time: no new request is taken until the engine is idle again; the walk reads each
// entry from a 64-entry bank and writes the rebuilt table into the other bank
// reset: synchronous active low; range registers clear, table is one free block
// reset needs no clearing pass; the first entry is taken from the range registers
`timescale 1ns / 1ps
`default_nettype none
module first_fit_aligned_region_allocator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire ffa_pkg::t_in_item                 i_in_data,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output ffa_pkg::t_out_item                     o_out_data,
    // register write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic                              i_cfg_index,
    input  wire logic [ffa_pkg::OFS_W-1:0]         i_cfg_data
);

    // range registers
    logic [ffa_pkg::OFS_W-1:0] r_heap_start;
    logic [ffa_pkg::OFS_W-1:0] r_heap_size;
    logic [ffa_pkg::OFS_W-1:0] w_room;
    logic [ffa_pkg::OFS_W-1:0] w_eff_size;
    ffa_pkg::t_entry           w_init_ent;
    logic                      w_cfg_wr;

    // engine handshake
    logic                      w_idle;
    logic                      w_start;
    logic                      w_res_valid;
    logic                      w_res_ready;
    ffa_pkg::t_out_item        w_res;

    // output register
    logic                      r_ov;
    ffa_pkg::t_out_item        r_out;

    // register writes only while the engine is idle, so the table reinit is never lost
    assign o_cfg_ready = w_idle;
    assign w_cfg_wr    = i_cfg_valid && w_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_start <= '0;
            r_heap_size  <= '0;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                ffa_pkg::CFG_HEAP_START: r_heap_start <= i_cfg_data;
                default:                 r_heap_size  <= i_cfg_data;
            endcase
        end
    end

    // the range is cut so that it does not run past the top of the offset space
    assign w_room     = ffa_pkg::TOP_LIMIT - r_heap_start;
    assign w_eff_size = (r_heap_size < w_room) ? r_heap_size : w_room;
    assign w_init_ent = '{ent_start: r_heap_start, ent_size: w_eff_size, ent_owner: '0};

    assign o_in_ready = w_idle;
    assign w_start    = i_in_valid && w_idle;

    // the engine may finish while the previous result still waits
    assign w_res_ready = !r_ov || i_out_ready;

    ffa_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (i_in_data),
        .o_idle      (w_idle),
        .i_cfg_wr    (w_cfg_wr),
        .i_init_ent  (w_init_ent),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: hw/rtl/ffa_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module ffa_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 70,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: hw/rtl/ffa_engine.sv
// table walk engine: streams the block table from one bank into the other
`timescale 1ns / 1ps
`default_nettype none
module ffa_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire ffa_pkg::t_in_item   i_item,
    output logic                     o_idle,
    input  wire logic                i_cfg_wr,
    input  wire ffa_pkg::t_entry     i_init_ent,
    output logic                     o_res_valid,
    output ffa_pkg::t_out_item       o_res,
    input  wire logic                i_res_ready
);

    localparam int EW = $bits(ffa_pkg::t_entry);
    localparam int AW = ffa_pkg::ARITH_W;
    localparam int OW = ffa_pkg::OFS_W;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_PROC, S_EMIT, S_FLUSH, S_OUT
    } t_state;

    t_state                          r_state;
    logic [1:0]                      r_op;
    logic [OW-1:0]                   r_req;
    logic [4:0]                      r_al;
    logic [OW-1:0]                   r_where;
    logic [ffa_pkg::OWN_W-1:0]       r_who;
    logic [ffa_pkg::CNT_W-1:0]       r_idx;
    logic [ffa_pkg::CNT_W-1:0]       r_w;
    logic [ffa_pkg::CNT_W-1:0]       r_count;
    logic                            r_bank;
    logic                            r_init;
    logic                            r_found;
    logic                            r_mnx;
    logic                            r_pv;
    ffa_pkg::t_entry                 r_p;
    ffa_pkg::t_entry                 r_q [3];
    logic [2:0]                      r_qm;
    logic [1:0]                      r_qn;
    logic [1:0]                      r_qi;
    ffa_pkg::t_status                r_status;
    logic [OW-1:0]                   r_off;

    logic [EW-1:0]                   w_rd0, w_rd1;
    logic                            w_we;
    ffa_pkg::t_entry                 w_wdata;
    ffa_pkg::t_entry                 w_ent;

    // per-entry decision
    logic [AW-1:0]                   w_s, w_e, w_mask, w_a, w_req;
    logic                            w_fits, w_pre, w_post, w_full;
    logic [ffa_pkg::CNT_W:0]         w_need_cnt;
    ffa_pkg::t_entry                 n_q [3];
    logic [2:0]                      n_qm;
    logic [1:0]                      n_qn;
    logic                            n_found, n_mnx, n_fail, n_take;
    ffa_pkg::t_status                n_fail_st;
    ffa_pkg::t_entry                 w_pre_e, w_alc_e, w_post_e, w_new;
    logic                            w_merge;

    ffa_ram #(.DEPTH(ffa_pkg::MAX_BLOCKS), .WIDTH(EW)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_we && r_bank),
        .i_waddr (r_w[ffa_pkg::IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[ffa_pkg::IDX_W-1:0]),
        .o_rdata (w_rd0)
    );

    ffa_ram #(.DEPTH(ffa_pkg::MAX_BLOCKS), .WIDTH(EW)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_we && !r_bank),
        .i_waddr (r_w[ffa_pkg::IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[ffa_pkg::IDX_W-1:0]),
        .o_rdata (w_rd1)
    );

    always_comb begin
        if (r_init) begin
            w_ent = i_init_ent;
        end else if (r_bank) begin
            w_ent = ffa_pkg::t_entry'(w_rd1);
        end else begin
            w_ent = ffa_pkg::t_entry'(w_rd0);
        end
    end

    // alignment and fit of the current entry
    always_comb begin
        w_s    = AW'(w_ent.ent_start);
        w_e    = w_s + AW'(w_ent.ent_size);
        w_req  = AW'(r_req);
        w_mask = (AW'(1) << r_al) - AW'(1);
        w_a    = (w_s + w_mask) & ~w_mask;
        w_fits = (w_ent.ent_owner == '0) && ((w_a + w_req) <= w_e);
        w_pre  = w_a > w_s;
        w_post = w_req < (w_e - w_a);
        w_need_cnt = (ffa_pkg::CNT_W+1)'(r_count) + (ffa_pkg::CNT_W+1)'(w_pre)
                   + (ffa_pkg::CNT_W+1)'(w_post);
        w_full = w_need_cnt > (ffa_pkg::CNT_W+1)'(ffa_pkg::MAX_BLOCKS);
        w_pre_e  = '{ent_start: w_ent.ent_start, ent_size: OW'(w_a - w_s), ent_owner: '0};
        w_alc_e  = '{ent_start: OW'(w_a), ent_size: r_req, ent_owner: r_who};
        w_post_e = '{ent_start: OW'(w_a + w_req), ent_size: OW'(w_e - w_a - w_req),
                     ent_owner: '0};
    end

    always_comb begin
        n_q[0]    = w_ent;
        n_q[1]    = w_ent;
        n_q[2]    = w_ent;
        n_qm      = 3'b000;
        n_qn      = 2'd1;
        n_found   = r_found;
        n_mnx     = 1'b0;
        n_fail    = 1'b0;
        n_take    = 1'b0;
        n_fail_st = ffa_pkg::ST_OK;
        unique case (r_op)
            ffa_pkg::OP_ALLOC: begin
                if (!r_found && w_fits) begin
                    if (w_full) begin
                        n_fail    = 1'b1;
                        n_fail_st = ffa_pkg::ST_TABLE_FULL;
                    end else begin
                        n_found = 1'b1;
                        n_take  = 1'b1;
                        if (w_pre) begin
                            n_q[0] = w_pre_e;
                            n_q[1] = w_alc_e;
                            n_q[2] = w_post_e;
                            n_qn   = w_post ? 2'd3 : 2'd2;
                        end else begin
                            n_q[0] = w_alc_e;
                            n_q[1] = w_post_e;
                            n_qn   = w_post ? 2'd2 : 2'd1;
                        end
                    end
                end
            end
            ffa_pkg::OP_FREE: begin
                if (!r_found && (w_ent.ent_start == r_where)) begin
                    if (w_ent.ent_owner != r_who) begin
                        n_fail    = 1'b1;
                        n_fail_st = ffa_pkg::ST_NOT_OWNER;
                    end else begin
                        n_q[0].ent_owner = '0;
                        n_qm    = 3'b001;
                        n_found = 1'b1;
                        n_mnx   = 1'b1;
                    end
                end else begin
                    n_qm = {2'b00, r_mnx};
                end
            end
            default: begin
                if (w_ent.ent_owner == r_who) begin
                    n_q[0].ent_owner = '0;
                end
                n_qm = 3'b001;
            end
        endcase
    end

    // push of one queued entry: merge it into the pending entry, or write the pending one out and hold it
    always_comb begin
        w_new   = r_q[r_qi];
        w_merge = r_pv && r_qm[r_qi] && (r_p.ent_owner == '0) && (w_new.ent_owner == '0);
        w_wdata = r_p;
        w_we    = 1'b0;
        if (r_state == S_EMIT) begin
            w_we = r_pv && !w_merge;
        end else if (r_state == S_FLUSH) begin
            w_we = r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bank  <= 1'b0;
            r_init  <= 1'b1;
            r_count <= ffa_pkg::CNT_W'(1);
            r_pv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_wr) begin
                        r_init  <= 1'b1;
                        r_count <= ffa_pkg::CNT_W'(1);
                    end
                    if (i_start) begin
                        r_op     <= i_item.operation;
                        r_req    <= i_item.request_size;
                        r_al     <= (i_item.align_log2 < ffa_pkg::MIN_ALIGN_LOG2)
                                    ? ffa_pkg::MIN_ALIGN_LOG2 : i_item.align_log2;
                        r_where  <= i_item.request_offset;
                        r_who    <= i_item.owner_id;
                        r_idx    <= '0;
                        r_w      <= '0;
                        r_found  <= 1'b0;
                        r_mnx    <= 1'b0;
                        r_pv     <= 1'b0;
                        r_off    <= '0;
                        r_status <= ffa_pkg::ST_OK;
                        if (i_item.owner_id == '0) begin
                            r_status <= ffa_pkg::ST_NOT_OWNER;
                            r_state  <= S_OUT;
                        end else if (i_item.operation != ffa_pkg::OP_ALLOC &&
                                     i_item.operation != ffa_pkg::OP_FREE &&
                                     i_item.operation != ffa_pkg::OP_RELEASE) begin
                            r_status <= ffa_pkg::ST_NOT_FOUND;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_idx == r_count) begin
                        if (r_op == ffa_pkg::OP_ALLOC && !r_found) begin
                            r_status <= ffa_pkg::ST_NO_SPACE;
                            r_state  <= S_OUT;
                        end else if (r_op == ffa_pkg::OP_FREE && !r_found) begin
                            r_status <= ffa_pkg::ST_NOT_FOUND;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_FLUSH;
                        end
                    end else begin
                        r_state <= S_PROC;
                    end
                end
                S_PROC: begin
                    if (n_fail) begin
                        r_status <= n_fail_st;
                        r_state  <= S_OUT;
                    end else begin
                        r_q[0]  <= n_q[0];
                        r_q[1]  <= n_q[1];
                        r_q[2]  <= n_q[2];
                        r_qm    <= n_qm;
                        r_qn    <= n_qn;
                        r_qi    <= '0;
                        r_found <= n_found;
                        r_mnx   <= n_mnx;
                        if (n_take) begin
                            r_off <= OW'(w_a);
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_merge) begin
                        r_p.ent_size <= r_p.ent_size + w_new.ent_size;
                    end else begin
                        if (r_pv) begin
                            r_w <= r_w + ffa_pkg::CNT_W'(1);
                        end
                        r_p  <= w_new;
                        r_pv <= 1'b1;
                    end
                    r_qi <= r_qi + 2'd1;
                    if (r_qi == r_qn - 2'd1) begin
                        r_idx   <= r_idx + ffa_pkg::CNT_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_FLUSH: begin
                    r_count <= r_pv ? r_w + ffa_pkg::CNT_W'(1) : r_w;
                    r_bank  <= !r_bank;
                    r_init  <= 1'b0;
                    r_pv    <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle             = (r_state == S_IDLE);
    assign o_res_valid        = (r_state == S_OUT);
    assign o_res.status       = r_status;
    assign o_res.block_offset = (r_status == ffa_pkg::ST_OK) ? r_off : '0;

endmodule
`default_nettype wire

FILE: test/tb.sv
// self-checking testbench of the first-fit aligned region allocator
`timescale 1ns / 1ps
`default_nettype none
module tb;

    localparam int IDLE_LIMIT = 20000;

    // allocator table mirror used to predict every result
    class region_table_scoreboard;
        logic [30:0] heap_base;
        logic [30:0] heap_len;
        logic [30:0] ent_base [ffa_pkg::MAX_BLOCKS];
        logic [30:0] ent_len [ffa_pkg::MAX_BLOCKS];
        logic [7:0]  ent_who [ffa_pkg::MAX_BLOCKS];
        int          used;
        ffa_pkg::t_out_item pending_results [$];
        int          fails;
        // offsets of blocks handed out, used to aim frees
        logic [30:0] granted [$];

        function void rebuild();
            logic [31:0] room;
            room = 32'h7FFF_FFFF - {1'b0, heap_base};
            for (int k = 0; k < ffa_pkg::MAX_BLOCKS; k++) begin
                ent_base[k] = '0;
                ent_len[k] = '0;
                ent_who[k] = '0;
            end
            ent_base[0] = heap_base;
            ent_len[0] = ({1'b0, heap_len} < room) ? heap_len : room[30:0];
            used = 1;
            granted.delete();
        endfunction

        function void set_reg(logic idx, logic [30:0] val);
            if (idx == ffa_pkg::CFG_HEAP_START) heap_base = val;
            else heap_len = val;
            rebuild();
        endfunction

        function void open_slot(int pos, logic [30:0] s, logic [30:0] z, logic [7:0] o);
            for (int k = used; k > pos; k--) begin
                ent_base[k] = ent_base[k-1];
                ent_len[k] = ent_len[k-1];
                ent_who[k] = ent_who[k-1];
            end
            ent_base[pos] = s;
            ent_len[pos] = z;
            ent_who[pos] = o;
            used++;
        endfunction

        function void join_next(int pos);
            ent_len[pos] = ent_len[pos] + ent_len[pos+1];
            for (int k = pos + 1; k + 1 < used; k++) begin
                ent_base[k] = ent_base[k+1];
                ent_len[k] = ent_len[k+1];
                ent_who[k] = ent_who[k+1];
            end
            used--;
            ent_base[used] = '0;
            ent_len[used] = '0;
            ent_who[used] = '0;
        endfunction

        function ffa_pkg::t_status carve(logic [30:0] req, logic [4:0] alog, logic [7:0] who,
                                         output logic [30:0] off);
            logic [4:0]  al;
            logic [63:0] mask, s, e, a;
            int          need;
            off = '0;
            al = (alog < ffa_pkg::MIN_ALIGN_LOG2) ? ffa_pkg::MIN_ALIGN_LOG2 : alog;
            mask = (64'd1 << al) - 64'd1;
            for (int i = 0; i < used; i++) begin
                s = ent_base[i];
                e = s + ent_len[i];
                a = (s + mask) & ~mask;
                if (ent_who[i] != 0 || a + req > e) continue;
                need = ((a > s) ? 1 : 0) + ((req < e - a) ? 1 : 0);
                if (used + need > ffa_pkg::MAX_BLOCKS) return ffa_pkg::ST_TABLE_FULL;
                if (a > s) begin
                    open_slot(i + 1, a[30:0], 31'(e - a), 8'd0);
                    ent_len[i] = 31'(a - s);
                    i++;
                end
                if (req < e - a) begin
                    open_slot(i + 1, 31'(a + req), 31'(e - a - req), 8'd0);
                    ent_len[i] = req;
                end
                ent_who[i] = who;
                off = a[30:0];
                return ffa_pkg::ST_OK;
            end
            return ffa_pkg::ST_NO_SPACE;
        endfunction

        function ffa_pkg::t_status give_back(logic [30:0] where, logic [7:0] who);
            for (int i = 0; i < used; i++) begin
                if (ent_base[i] != where) continue;
                if (ent_who[i] != who) return ffa_pkg::ST_NOT_OWNER;
                ent_who[i] = '0;
                if (i + 1 < used && ent_who[i+1] == 0) join_next(i);
                if (i > 0 && ent_who[i-1] == 0) join_next(i - 1);
                return ffa_pkg::ST_OK;
            end
            return ffa_pkg::ST_NOT_FOUND;
        endfunction

        function void drop_owner(logic [7:0] who);
            int i;
            for (i = 0; i < used; i++)
                if (ent_who[i] == who) ent_who[i] = '0;
            i = 0;
            while (i + 1 < used) begin
                if (ent_who[i] == 0 && ent_who[i+1] == 0) join_next(i);
                else i++;
            end
        endfunction

        function void note_request(ffa_pkg::t_in_item it);
            ffa_pkg::t_out_item r;
            logic [30:0] off;
            off = '0;
            if (it.owner_id == 0) r.status = ffa_pkg::ST_NOT_OWNER;
            else if (it.operation == ffa_pkg::OP_ALLOC)
                r.status = carve(it.request_size, it.align_log2, it.owner_id, off);
            else if (it.operation == ffa_pkg::OP_FREE)
                r.status = give_back(it.request_offset, it.owner_id);
            else if (it.operation == ffa_pkg::OP_RELEASE) begin
                drop_owner(it.owner_id);
                r.status = ffa_pkg::ST_OK;
            end else r.status = ffa_pkg::ST_NOT_FOUND;
            if (r.status != ffa_pkg::ST_OK) off = '0;
            if (it.operation == ffa_pkg::OP_ALLOC && r.status == ffa_pkg::ST_OK)
                granted.push_back(off);
            r.block_offset = off;
            pending_results.push_back(r);
        endfunction

        function void check_result(ffa_pkg::t_out_item got);
            ffa_pkg::t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result with none expected: status %0d offset %h",
                       got.status, got.block_offset);
                fails++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d actual %0d", want.status, got.status);
                fails++;
            end
            if (got.block_offset !== want.block_offset) begin
                $error("block_offset: expected %h actual %h",
                       want.block_offset, got.block_offset);
                fails++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid, in_ready;
    ffa_pkg::t_in_item  in_data;
    logic      out_valid, out_ready;
    ffa_pkg::t_out_item out_data;
    logic      cfg_valid, cfg_ready;
    logic      cfg_index;
    logic [30:0] cfg_data;

    region_table_scoreboard sb;
    int  idle_cycles;
    bit  stall_pattern_on;

    first_fit_aligned_region_allocator dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver: sample results at the edge; while the stall pattern is on, stall on a rotating pattern
    initial begin
        int phase;
        phase = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) sb.check_result(out_data);
            phase++;
            if (!stall_pattern_on) out_ready <= 1'b1;
            else out_ready <= ((phase % 7) < 4) ? 1'b1 : ($urandom_range(0, 2) == 0);
        end
    end

    // watchdog: cycles in which nothing moves on any channel
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // the block is busy right after an accept, so the pause after each item costs nothing
    task automatic send_item(ffa_pkg::t_in_item it);
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_request(it);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // random gap between bursts, sometimes none
    task automatic burst_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        repeat (gap) @(posedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0) @(posedge clk);
        // every item yields a result, so a short settle is enough
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [30:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic ffa_pkg::t_in_item make_item(logic [1:0] op, logic [30:0] sz,
                                                    logic [4:0] al, logic [30:0] ofs,
                                                    logic [7:0] who);
        ffa_pkg::t_in_item it;
        it.operation = op;
        it.request_size = sz;
        it.align_log2 = al;
        it.request_offset = ofs;
        it.owner_id = who;
        return it;
    endfunction

    // mostly well-formed traffic: allocs, frees of granted blocks, releases
    function automatic ffa_pkg::t_in_item random_item();
        int          pick;
        logic [30:0] sz, ofs;
        logic [7:0]  who;
        pick = $urandom_range(0, 99);
        who = ($urandom_range(0, 40) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
        if ($urandom_range(0, 30) == 0) who = 8'($urandom_range(1, 255));
        case ($urandom_range(0, 5))
            0: sz = 31'($urandom_range(0, 16));
            1: sz = 31'($urandom);
            default: sz = 31'($urandom_range(1, 40000));
        endcase
        ofs = 31'($urandom);
        if (sb.granted.size() != 0 && $urandom_range(0, 3) != 0)
            ofs = sb.granted[$urandom_range(0, sb.granted.size() - 1)];
        if (pick < 55)
            return make_item(ffa_pkg::OP_ALLOC, sz, 5'($urandom_range(0, 31)), ofs, who);
        else if (pick < 85)
            return make_item(ffa_pkg::OP_FREE, sz, 5'($urandom), ofs, who);
        else if (pick < 95)
            return make_item(ffa_pkg::OP_RELEASE, sz, 5'($urandom), ofs, who);
        else return make_item(2'($urandom), 31'($urandom), 5'($urandom), ofs, who);
    endfunction

    task automatic run_random(int n);
        int left;
        left = n;
        while (left > 0) begin
            int burst;
            burst = $urandom_range(1, 10);
            while (burst > 0 && left > 0) begin
                send_item(random_item());
                burst--;
                left--;
            end
            burst_gap();
        end
    endtask

    initial begin
        sb = new();
        sb.fails = 0;
        sb.heap_base = '0;
        sb.heap_len = '0;
        sb.rebuild();
        stall_pattern_on = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= ffa_pkg::CFG_HEAP_START;
        cfg_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty range after reset: everything but a zero-size alloc at 0 misses
        send_item(make_item(ffa_pkg::OP_ALLOC, 31'd1, 5'd0, 31'd0, 8'd1));
        send_item(make_item(ffa_pkg::OP_ALLOC, 31'd0, 5'd0, 31'd0, 8'd1));
        wait_drained();

        // range running past the top gets trimmed
        write_reg(ffa_pkg::CFG_HEAP_START, 31'h7FFF_0123);
        write_reg(ffa_pkg::CFG_HEAP_SIZE, 31'h7FFF_FFFF);
        send_item(make_item(ffa_pkg::OP_ALLOC, 31'h100, 5'd12, 31'd0, 8'd255));
        send_item(make_item(ffa_pkg::OP_ALLOC, 31'h7FFF_FFFF, 5'd31, 31'd0, 8'd2));
        send_item(make_item(ffa_pkg::OP_RELEASE, 31'd0, 5'd0, 31'd0, 8'd255));
        wait_drained();

        // directed: special cases on a moderate unaligned heap
        write_reg(ffa_pkg::CFG_HEAP_START, 31'h0000_0800);
        write_reg(ffa_pkg::CFG_HEAP_SIZE, 31'h0010_0000);
        send_item(make_item(ffa_pkg::OP_ALLOC, 31'h1000, 5'd3, 31'd0, 8'd0));   // owner zero
        send_item(make_item(2'd3, 31'h1000, 5'd3, 31'd0, 8'd1));                // unknown op
        send_item(make_item(ffa_pkg::OP_ALLOC, 31'h1000, 5'd3, 31'd0, 8'd1));   // raised align
        send_item(make_item(ffa_pkg::OP_ALLOC, 31'd0, 5'd16, 31'd0, 8'd2));     // zero size
        send_item(make_item(ffa_pkg::OP_ALLOC, 31'h7FFF_FFFF, 5'd30, 31'd0, 8'd3)); // no space
        send_item(make_item(ffa_pkg::OP_ALLOC, 31'h123, 5'd13, 31'd0, 8'd3));
        send_item(make_item(ffa_pkg::OP_FREE, 31'd0, 5'd0, 31'h1000, 8'd2));    // wrong owner
        send_item(make_item(ffa_pkg::OP_FREE, 31'd0, 5'd0, 31'h0800, 8'd1));    // free block
        send_item(make_item(ffa_pkg::OP_FREE, 31'd0, 5'd0, 31'h0001, 8'd1));    // not found
        send_item(make_item(ffa_pkg::OP_FREE, 31'd0, 5'd0, 31'h1000, 8'd1));
        send_item(make_item(ffa_pkg::OP_RELEASE, 31'd0, 5'd0, 31'd0, 8'd9));    // owns nothing
        send_item(make_item(ffa_pkg::OP_RELEASE, 31'd0, 5'd0, 31'd0, 8'd3));
        // many small aligned allocs to run into table_full
        for (int k = 0; k < 40; k++)
            send_item(make_item(ffa_pkg::OP_ALLOC, 31'h10, 5'd12, 31'd0, 8'd4));
        send_item(make_item(ffa_pkg::OP_RELEASE, 31'd0, 5'd0, 31'd0, 8'd4));
        wait_drained();

        // random phases across several range settings
        stall_pattern_on = 1'b1;
        write_reg(ffa_pkg::CFG_HEAP_START, 31'h0000_0000);
        write_reg(ffa_pkg::CFG_HEAP_SIZE, 31'h0004_0000);
        run_random(150);
        wait_drained();
        write_reg(ffa_pkg::CFG_HEAP_START, 31'($urandom));
        write_reg(ffa_pkg::CFG_HEAP_SIZE, 31'($urandom_range(0, 31'h0040_0000)));
        run_random(100);
        wait_drained();
        stall_pattern_on = 1'b0;
        write_reg(ffa_pkg::CFG_HEAP_SIZE, 31'h7FFF_FFFF);
        write_reg(ffa_pkg::CFG_HEAP_START, 31'h0000_0000);
        run_random(80);
        wait_drained();
        stall_pattern_on = 1'b1;
        write_reg(ffa_pkg::CFG_HEAP_START, 31'h7FFF_FFFF);
        run_random(20);
        wait_drained();
        // final latency allowance
        repeat (250) @(posedge clk);

        if (sb.fails == 0 && sb.pending_results.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_ram.sv
hw/rtl/ffa_engine.sv
hw/rtl/first_fit_aligned_region_allocator.sv
test/tb.sv
